[rtl/pfb_pkg.sv]
// pfb_pkg: shared sizes, codes and control/status structs of the page framebuffer
// used by pfb_ctrl, pfb_dp and the top level; depends on nothing
package pfb_pkg;

  // store geometry
  localparam int MAX_WIDTH   = 128;
  localparam int MAX_HEIGHT  = 64;
  localparam int STORE_PAGES = (MAX_HEIGHT + 7) / 8;
  localparam int STORE_DEPTH = MAX_WIDTH * STORE_PAGES;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int PAGE_W      = (STORE_PAGES > 1) ? $clog2(STORE_PAGES) : 1;
  localparam int WIDTH_W     = $clog2(MAX_WIDTH + 1);
  localparam int HEIGHT_W    = $clog2(MAX_HEIGHT + 1);

  // port widths
  localparam int CFG_W_W   = 8;
  localparam int CFG_H_W   = 7;
  localparam int CFG_DAT_W = 8;
  localparam int PAYLOAD_W = 64;
  localparam int BCNT_W    = 4;

  // request modes
  localparam logic [1:0] MODE_PIXEL   = 2'd0;
  localparam logic [1:0] MODE_FILL    = 2'd1;
  localparam logic [1:0] MODE_REFRESH = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_CMD    = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // configuration register indexes
  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  // panel command bytes
  localparam logic [7:0] CMD_PAGE   = 8'hB0;
  localparam logic [7:0] CMD_COL_HI = 8'h10;
  localparam logic [7:0] CMD_COL_LO = 8'h00;
  localparam logic [7:0] FILL_ONES  = 8'hFF;
  localparam logic [7:0] FILL_ZERO  = 8'h00;

  typedef enum logic [1:0] {
    WD_ZERO,
    WD_FILL,
    WD_PIXEL
  } wd_sel_e;

  typedef enum logic [2:0] {
    OS_ERR,
    OS_ACK,
    OS_PAGE,
    OS_COLH,
    OS_COLL,
    OS_PIX,
    OS_BEAT
  } out_sel_e;

  // controller -> datapath
  typedef struct packed {
    logic     cap_in;
    logic     calc_base;
    logic     cnt_clr;
    logic     cnt_inc;
    logic     mem_re;
    logic     mem_we;
    wd_sel_e  wd_sel;
    logic     pix_load;
    logic     pack;
    logic     beat_clr;
    logic     out_load;
    out_sel_e out_sel;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] mode;
    logic       err;
    logic       sweep_done;
    logic       last_byte;
    logic       beat_full;
    logic       out_free;
  } sts_t;

endpackage

[rtl/pfb_ram.sv]
// pfb_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module pfb_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/pfb_ctrl.sv]
// pfb_ctrl: sequencer for clear, fill, pixel write and page refresh
// depends on pfb_pkg
module pfb_ctrl import pfb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_FILL  = 4'd3;
  localparam logic [3:0] S_ACK   = 4'd4;
  localparam logic [3:0] S_ERR   = 4'd5;
  localparam logic [3:0] S_PRD   = 4'd6;
  localparam logic [3:0] S_PMOD  = 4'd7;
  localparam logic [3:0] S_PAGE  = 4'd8;
  localparam logic [3:0] S_COLH  = 4'd9;
  localparam logic [3:0] S_COLL  = 4'd10;
  localparam logic [3:0] S_PDATA = 4'd11;
  localparam logic [3:0] S_RRD   = 4'd12;
  localparam logic [3:0] S_RCAP  = 4'd13;
  localparam logic [3:0] S_REMIT = 4'd14;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.wd_sel  = WD_ZERO;
    cmd_o.out_sel = OS_ACK;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.wd_sel = WD_ZERO;
        if (sts_i.sweep_done) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = S_IDLE;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          state_d      = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.calc_base = 1'b1;
        cmd_o.cnt_clr   = 1'b1;
        cmd_o.beat_clr  = 1'b1;
        unique case (sts_i.mode)
          MODE_PIXEL:   state_d = sts_i.err ? S_ERR : S_PRD;
          MODE_REFRESH: state_d = sts_i.err ? S_ERR : S_PAGE;
          MODE_FILL:    state_d = S_FILL;
          default:      state_d = S_IDLE;
        endcase
      end
      S_FILL: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.wd_sel = WD_FILL;
        if (sts_i.sweep_done) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = S_ACK;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      S_ACK: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OS_ACK;
          state_d        = S_IDLE;
        end
      end
      S_ERR: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OS_ERR;
          state_d        = S_IDLE;
        end
      end
      S_PRD: begin
        cmd_o.mem_re = 1'b1;
        state_d      = S_PMOD;
      end
      S_PMOD: begin
        cmd_o.pix_load = 1'b1;
        cmd_o.mem_we   = 1'b1;
        cmd_o.wd_sel   = WD_PIXEL;
        state_d        = S_PAGE;
      end
      S_PAGE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OS_PAGE;
          state_d        = S_COLH;
        end
      end
      S_COLH: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OS_COLH;
          state_d        = S_COLL;
        end
      end
      S_COLL: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OS_COLL;
          state_d        = (sts_i.mode == MODE_PIXEL) ? S_PDATA : S_RRD;
        end
      end
      S_PDATA: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OS_PIX;
          state_d        = S_IDLE;
        end
      end
      S_RRD: begin
        cmd_o.mem_re = 1'b1;
        state_d      = S_RCAP;
      end
      S_RCAP: begin
        cmd_o.pack = 1'b1;
        if (sts_i.last_byte || sts_i.beat_full) begin
          state_d = S_REMIT;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d       = S_RRD;
        end
      end
      S_REMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OS_BEAT;
          cmd_o.beat_clr = 1'b1;
          if (sts_i.last_byte) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.cnt_inc = 1'b1;
            state_d       = S_RRD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/pfb_dp.sv]
// pfb_dp: request and config registers, frame store, byte packing, result register
// depends on pfb_pkg and pfb_ram
module pfb_dp import pfb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  input  logic [1:0]           mode_i,
  input  logic [7:0]           col_i,
  input  logic [7:0]           row_i,
  input  logic                 color_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [1:0]           kind_o,
  output logic [PAYLOAD_W-1:0] payload_o,
  output logic [BCNT_W-1:0]    byte_count_o,
  output logic                 status_o,
  output logic                 last_o,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o
);

  logic [CFG_W_W-1:0]   cfg_width_q;
  logic [CFG_H_W-1:0]   cfg_height_q;
  logic [WIDTH_W-1:0]   w_eff;
  logic [HEIGHT_W-1:0]  h_eff;
  logic [8:0]           w_ext, h_ext;

  logic [1:0]           mode_q;
  logic [7:0]           col_q, row_q;
  logic                 color_q;
  logic [ADDR_W-1:0]    base_q, cnt_q;
  logic [7:0]           byte_q;
  logic [PAYLOAD_W-1:0] beat_q;

  logic [ADDR_W-1:0]    pix_addr, raddr, waddr;
  logic [7:0]           wdata, rdata, pix_byte;
  logic [7:0]           cur_col;
  logic [PAGE_W+WIDTH_W-1:0] base_full;

  logic                 out_valid_q;
  logic [1:0]           kind_q;
  logic [PAYLOAD_W-1:0] payload_q;
  logic [BCNT_W-1:0]    bcnt_q;
  logic                 status_q, last_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= CFG_W_W'(MAX_WIDTH);
      cfg_height_q <= CFG_H_W'(MAX_HEIGHT);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IDX_WIDTH:  cfg_width_q  <= cfg_data_i[CFG_W_W-1:0];
        CFG_IDX_HEIGHT: cfg_height_q <= cfg_data_i[CFG_H_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp to the panel limits, height in whole pages
  always_comb begin
    w_ext = 9'(cfg_width_q);
    if (w_ext < 9'd8) w_ext = 9'd8;
    if (w_ext > 9'(MAX_WIDTH)) w_ext = 9'(MAX_WIDTH);
    h_ext = 9'(cfg_height_q);
    if (h_ext < 9'd8) h_ext = 9'd8;
    if (h_ext > 9'(MAX_HEIGHT)) h_ext = 9'(MAX_HEIGHT);
    h_ext = h_ext & ~9'd7;
    w_eff = w_ext[WIDTH_W-1:0];
    h_eff = h_ext[HEIGHT_W-1:0];
  end

  assign base_full = row_q[PAGE_W+2:3] * w_eff;
  assign pix_addr  = base_q + ADDR_W'(col_q);
  assign raddr     = (mode_q == MODE_PIXEL) ? pix_addr : base_q + cnt_q;
  assign cur_col   = (mode_q == MODE_PIXEL) ? col_q : 8'd0;
  assign pix_byte  = (rdata & ~(8'd1 << row_q[2:0])) | (8'(color_q) << row_q[2:0]);

  always_comb begin
    case (cmd_i.wd_sel)
      WD_FILL:  wdata = color_q ? FILL_ONES : FILL_ZERO;
      WD_PIXEL: wdata = pix_byte;
      default:  wdata = FILL_ZERO;
    endcase
  end
  assign waddr = (cmd_i.wd_sel == WD_PIXEL) ? pix_addr : cnt_q;

  pfb_ram #(
    .Width (8),
    .Depth (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.mem_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.mem_re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // sweep / byte counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      mode_q <= '0;
    end else begin
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + ADDR_W'(1);
      end
      if (cmd_i.cap_in) begin
        mode_q <= mode_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      col_q   <= col_i;
      row_q   <= row_i;
      color_q <= color_i;
    end
    if (cmd_i.calc_base) begin
      base_q <= base_full[ADDR_W-1:0];
    end
    if (cmd_i.pix_load) begin
      byte_q <= pix_byte;
    end
    if (cmd_i.beat_clr) begin
      beat_q <= '0;
    end else if (cmd_i.pack) begin
      beat_q[8*cnt_q[2:0] +: 8] <= rdata;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      kind_q    <= KIND_CMD;
      payload_q <= '0;
      bcnt_q    <= BCNT_W'(1);
      status_q  <= 1'b0;
      last_q    <= 1'b0;
      case (cmd_i.out_sel)
        OS_ERR: begin
          kind_q   <= KIND_STATUS;
          bcnt_q   <= '0;
          status_q <= 1'b1;
          last_q   <= 1'b1;
        end
        OS_ACK: begin
          kind_q <= KIND_STATUS;
          bcnt_q <= '0;
          last_q <= 1'b1;
        end
        OS_PAGE: payload_q <= PAYLOAD_W'(CMD_PAGE | {4'd0, row_q[6:3]});
        OS_COLH: payload_q <= PAYLOAD_W'(CMD_COL_HI | {4'd0, cur_col[7:4]});
        OS_COLL: payload_q <= PAYLOAD_W'(CMD_COL_LO | {4'd0, cur_col[3:0]});
        OS_PIX: begin
          kind_q    <= KIND_DATA;
          payload_q <= PAYLOAD_W'(byte_q);
          last_q    <= 1'b1;
        end
        OS_BEAT: begin
          kind_q    <= KIND_DATA;
          payload_q <= beat_q;
          bcnt_q    <= BCNT_W'(cnt_q[2:0]) + BCNT_W'(1);
          last_q    <= sts_o.last_byte;
        end
        default: ;
      endcase
    end
  end

  assign sts_o.mode       = mode_q;
  assign sts_o.err        = (9'(row_q) >= 9'(h_eff)) ||
                            ((mode_q == MODE_PIXEL) && (9'(col_q) >= 9'(w_eff)));
  assign sts_o.sweep_done = (cnt_q == ADDR_W'(STORE_DEPTH - 1));
  assign sts_o.last_byte  = (cnt_q == ADDR_W'(w_eff) - ADDR_W'(1));
  assign sts_o.beat_full  = (cnt_q[2:0] == 3'd7);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign payload_o    = payload_q;
  assign byte_count_o = bcnt_q;
  assign status_o     = status_q;
  assign last_o       = last_q;

endmodule

[rtl/page_framebuffer_pixel_refresh.sv]
// page framebuffer: pixel write rewrites a store byte, then sends page, column, data bytes
// refresh of a page: the address commands, then the bytes read, packed into beats of up to eight
// fill: one store byte per cycle over all STORE_DEPTH bytes, plus the acknowledge
// after reset a clearing pass over the whole store zeroes it, requests held off
// configuration resets to 128 columns by 64 rows; one request in flight at a time
// depends on pfb_pkg, pfb_ctrl, pfb_dp, pfb_ram
module page_framebuffer_pixel_refresh import pfb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           mode_i,
  input  logic [7:0]           col_i,
  input  logic [7:0]           row_i,
  input  logic                 color_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           kind_o,
  output logic [PAYLOAD_W-1:0] payload_o,
  output logic [BCNT_W-1:0]    byte_count_o,
  output logic                 status_o,
  output logic                 last_o
);

  // the sequencer drives the datapath through one command bundle and
  // watches a small status bundle; the result register lives in the
  // datapath so a new request can be taken while the final result waits
  cmd_t cmd;
  sts_t sts;

  pfb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: clamped panel size, page base address, read-modify-write of
  // one store byte, eight-byte beat packing, result register
  pfb_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .mode_i       (mode_i),
    .col_i        (col_i),
    .row_i        (row_i),
    .color_i      (color_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .kind_o       (kind_o),
    .payload_o    (payload_o),
    .byte_count_o (byte_count_o),
    .status_o     (status_o),
    .last_o       (last_o),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule
